FILE: design/pel_pkg.sv
// shared types and constants for the positional list engine
// used by pel_cell and positional_list_engine; depends on nothing
package pel_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int SLOT_W  = 9;
    localparam int COUNT_W = 9;

    // request kinds
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // status codes
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic              ins_ok;
        logic              del_ok;
        logic [SLOT_W-1:0] slot;
    } t_cell_ctl;

endpackage

FILE: design/pel_cell.sv
// one list cell: holds one entry and trades it with its neighbors
// depends on pel_pkg
module pel_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  pel_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [pel_pkg::VALUE_W-1:0]  i_value,
    input  logic signed [pel_pkg::VALUE_W-1:0]  i_left,
    input  logic signed [pel_pkg::VALUE_W-1:0]  i_right,
    output logic signed [pel_pkg::VALUE_W-1:0]  o_entry,
    output logic signed [pel_pkg::VALUE_W-1:0]  o_hit
);

    localparam logic [pel_pkg::SLOT_W-1:0] Idx = pel_pkg::SLOT_W'(IDX);

    logic signed [pel_pkg::VALUE_W-1:0] r_entry;
    logic                               at_slot;
    logic                               above;

    // position of this cell relative to the addressed slot
    assign at_slot = (i_ctl.slot == Idx);
    assign above   = (Idx > i_ctl.slot);

    // insert shifts up from the left, delete closes the gap from the right
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_ok) begin
            if (at_slot) begin
                r_entry <= i_value;
            end else if (above) begin
                r_entry <= i_left;
            end
        end else if (i_ctl.del_ok) begin
            if (at_slot || above) begin
                r_entry <= i_right;
            end
        end
    end

    assign o_entry = r_entry;
    // this cell's share of the read mux
    assign o_hit   = at_slot ? r_entry : '0;

endmodule

FILE: design/positional_list_engine.sv
// top level of the positional list engine: request decode, cell chain, result register
// depends on pel_pkg and pel_cell
//
// Usage:
//   Input channel: i_valid / o_stall carry one request (i_req_type, i_position,
//   i_value). A request is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one result per request (o_status,
//   o_read_value, o_entry_count), taken when o_valid is high and i_stall low.
//   Insert, delete and get each finish in the cycle they are taken: every cell of
//   the chain loads its new entry from itself, its neighbor or the request at once,
//   and the result shows in the output register in the next cycle.
//   Throughput is one request per cycle while the receiver does not stall.
//   Get reads through a one-hot mux over all CAPACITY cells.
//   The output register holds its result while i_stall is high; a new request is
//   still taken in the cycle the held result leaves, and o_stall is high only while
//   a result waits and the receiver stalls.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
//   Entries are not cleared; only entries below the count are ever read.
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [pel_pkg::POS_W-1:0]           i_position,
    input  logic signed [pel_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic signed [pel_pkg::VALUE_W-1:0]  o_read_value,
    output logic [pel_pkg::COUNT_W-1:0]         o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [pel_pkg::SLOT_W-1:0] Cap = pel_pkg::SLOT_W'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_valid;
    logic          r_status;
    logic signed [pel_pkg::VALUE_W-1:0] r_read_value;
    logic [pel_pkg::COUNT_W-1:0]        r_entry_count;

    logic                          in_acc;
    logic [pel_pkg::SLOT_W-1:0]    pos9;
    logic [pel_pkg::SLOT_W-1:0]    cnt9;
    logic                          ins_ok;
    logic                          del_ok;
    logic                          get_ok;
    pel_pkg::t_cell_ctl            ctl;
    pel_pkg::t_req                 req;
    logic signed [pel_pkg::VALUE_W-1:0] rd_mux;

    logic signed [pel_pkg::VALUE_W-1:0] entry [CAPACITY];
    logic signed [pel_pkg::VALUE_W-1:0] hit   [CAPACITY];

    // handshake: take a request unless a held result is stalled
    assign o_stall = r_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // range checks on the request
    assign req  = pel_pkg::t_req'(i_req_type);
    assign pos9 = pel_pkg::SLOT_W'(i_position);
    assign cnt9 = pel_pkg::SLOT_W'(r_count);

    always_comb begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        get_ok = 1'b0;
        unique case (req)
            pel_pkg::REQ_INSERT: ins_ok = (cnt9 != Cap) && (pos9 != '0) && (pos9 <= cnt9 + 1'b1);
            pel_pkg::REQ_DELETE: del_ok = (pos9 != '0) && (pos9 <= cnt9);
            pel_pkg::REQ_GET:    get_ok = (pos9 != '0) && (pos9 <= cnt9);
            default: ;
        endcase
    end

    // broadcast to the cells
    always_comb begin
        ctl.ins_ok = in_acc && ins_ok;
        ctl.del_ok = in_acc && del_ok;
        ctl.slot   = pos9 - 1'b1;
    end

    // cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [pel_pkg::VALUE_W-1:0] left;
        logic signed [pel_pkg::VALUE_W-1:0] right;
        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid
            assign left = entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = entry[k+1];
        end
        pel_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (i_value),
            .i_left  (left),
            .i_right (right),
            .o_entry (entry[k]),
            .o_hit   (hit[k])
        );
    end

    // read mux: at most one cell drives a nonzero hit
    always_comb begin
        rd_mux = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_mux = rd_mux | hit[k];
        end
    end

    // next count
    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (del_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    // count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status      <= (ins_ok || del_ok || get_ok) ? pel_pkg::ST_DONE
                                                          : pel_pkg::ST_ERROR;
            r_read_value  <= get_ok ? rd_mux : '0;
            r_entry_count <= pel_pkg::COUNT_W'(n_count);
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_entry_count;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt9 <= Cap)
        else $error("entry count above capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted request left no result");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ins_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_error_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !ins_ok && !del_ok) |=> $stable(r_count))
        else $error("count changed without insert or delete");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for positional_list_engine: directed table, then random requests
// keeps its own shadow of the list to predict every result; depends on pel_pkg and the design
module testbench;

    import pel_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int RAND_ITEMS = 700;
    localparam int IDLE_PCT   = 33;
    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic                      status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
    } t_result;

    typedef struct {
        t_req                      kind;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] val;
        bit                        typed;
        t_result                   want;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_req_type = REQ_NONE;
    logic [POS_W-1:0]           i_position = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic                       o_status;
    logic signed [VALUE_W-1:0]  o_read_value;
    logic [COUNT_W-1:0]         o_entry_count;

    // shadow of the list and its fill level
    logic signed [VALUE_W-1:0]  shadow_list [CAPACITY];
    int                         shadow_count = 0;

    t_result                    pending_results [$];
    t_row                       directed_rows [$];
    t_result                    oldest_result;
    int                         mismatch_count = 0;
    int                         quiet_cycles = 0;
    bit                         quiet = 1'b0;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_position(i_position),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_read_value(o_read_value),
        .o_entry_count(o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    // apply one request to the shadow list and return the result it gives
    function automatic t_result list_apply(t_req kind, logic [POS_W-1:0] pos,
                                           logic signed [VALUE_W-1:0] val);
        t_result r;
        int      p;
        int      k;
        p = pos;
        r.status = ST_ERROR;
        r.read_value = '0;
        case (kind)
            REQ_INSERT: begin
                if (shadow_count < CAPACITY && p >= 1 && p <= shadow_count + 1) begin
                    for (k = shadow_count; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = val;
                    shadow_count++;
                    r.status = ST_DONE;
                end
            end
            REQ_DELETE: begin
                if (p >= 1 && p <= shadow_count) begin
                    for (k = p - 1; k < shadow_count - 1; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_count--;
                    r.status = ST_DONE;
                end
            end
            REQ_GET: begin
                if (p >= 1 && p <= shadow_count) begin
                    r.read_value = shadow_list[p-1];
                    r.status = ST_DONE;
                end
            end
            default: begin
                r.status = ST_ERROR;
            end
        endcase
        r.entry_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // append a row to the directed table
    task automatic add_row(t_req kind, int pos, logic signed [VALUE_W-1:0] val, bit typed,
                           logic st, logic signed [VALUE_W-1:0] rd, int cnt);
        t_row row;
        row.kind = kind;
        row.pos = POS_W'(pos);
        row.val = val;
        row.typed = typed;
        row.want.status = st;
        row.want.read_value = rd;
        row.want.entry_count = COUNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    // drive one request, called and returning at a falling edge
    task automatic send_request(t_row row);
        t_result predicted;
        bit      taken;
        taken = 1'b0;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req_type = row.kind;
        i_position = row.pos;
        i_value = row.val;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_stall) begin
                taken = 1'b1;
                predicted = list_apply(row.kind, row.pos, row.val);
                pending_results.push_back(row.typed ? row.want : predicted);
            end
            @(negedge i_clk);
        end
    endtask

    // receiver stalls at random outside the quiet stretch
    always @(negedge i_clk) begin
        if (quiet_cycles > 0)
            quiet_cycles = quiet_cycles - 1;
        i_stall = !(quiet || quiet_cycles > 0) && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d read=%0d count=%0d",
                         $time, o_status, o_read_value, o_entry_count);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_result.status, o_status);
                    mismatch_count++;
                end
                if (o_read_value !== oldest_result.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, oldest_result.read_value, o_read_value);
                    mismatch_count++;
                end
                if (o_entry_count !== oldest_result.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, oldest_result.entry_count, o_entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row row;
        int   n;
        int   k;
        int   pick;
        int   limit;
        int   ins_pct;
        int   del_pct;

        // hold reset, then release it
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: empty list, bad positions, extremes, fill to full, full list, deletes
        add_row(REQ_GET,    1,   0,             1, ST_ERROR, 0, 0);
        add_row(REQ_DELETE, 1,   0,             1, ST_ERROR, 0, 0);
        add_row(REQ_INSERT, 0,   32'sd5,        1, ST_ERROR, 0, 0);
        add_row(REQ_INSERT, 2,   32'sd5,        1, ST_ERROR, 0, 0);
        add_row(REQ_INSERT, 1,   32'h7fff_ffff, 1, ST_DONE,  0, 1);
        add_row(REQ_INSERT, 1,   32'h8000_0000, 1, ST_DONE,  0, 2);
        add_row(REQ_GET,    1,   0,             1, ST_DONE,  32'h8000_0000, 2);
        add_row(REQ_GET,    2,   -1,            1, ST_DONE,  32'h7fff_ffff, 2);
        add_row(REQ_GET,    3,   0,             1, ST_ERROR, 0, 2);
        add_row(REQ_NONE,   1,   -1,            1, ST_ERROR, 0, 2);
        add_row(REQ_DELETE, 255, 0,             1, ST_ERROR, 0, 2);
        for (k = 3; k <= CAPACITY; k++)
            add_row(REQ_INSERT, (k % 3 == 0) ? 1 : k, 32'(k) * 32'h1357_9bdf, 0,
                    ST_DONE, 0, 0);
        add_row(REQ_INSERT, 17,  32'sd1,        1, ST_ERROR, 0, 16);
        add_row(REQ_INSERT, 1,   -1,            1, ST_ERROR, 0, 16);
        add_row(REQ_GET,    16,  0,             0, ST_DONE,  0, 0);
        add_row(REQ_DELETE, 16,  0,             1, ST_DONE,  0, 15);
        add_row(REQ_GET,    255, 0,             1, ST_ERROR, 0, 15);
        add_row(REQ_DELETE, 1,   0,             0, ST_DONE,  0, 0);
        add_row(REQ_GET,    1,   0,             0, ST_DONE,  0, 0);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // random part: alternating fill and drain phases with some noise
        for (n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= 300 && n < 400);
            if (n == 200)
                quiet_cycles = 150;

            // sender holds off until all results are back
            if (n == 500) begin
                i_valid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge i_clk);
            end

            row.typed = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                row.val = (pick < 3) ? 32'h7fff_ffff : (pick < 6) ? 32'h8000_0000 :
                          (pick < 8) ? 32'sd0 : -32'sd1;
            else
                row.val = $urandom;

            if ($urandom_range(0, 99) < 8) begin
                row.kind = t_req'($urandom_range(0, 3));
                row.pos = POS_W'($urandom_range(0, 255));
            end else begin
                ins_pct = ((n / 90) % 2 == 0) ? 65 : 20;
                del_pct = ((n / 90) % 2 == 0) ? 15 : 60;
                pick = $urandom_range(0, 99);
                if (pick < ins_pct)
                    row.kind = REQ_INSERT;
                else if (pick < ins_pct + del_pct)
                    row.kind = REQ_DELETE;
                else
                    row.kind = REQ_GET;
                limit = (row.kind == REQ_INSERT) ? shadow_count + 1 : shadow_count;
                pick = $urandom_range(0, 99);
                if (limit == 0)
                    row.pos = POS_W'($urandom_range(0, 1));
                else if (pick < 10)
                    row.pos = POS_W'(limit);
                else if (pick < 20)
                    row.pos = POS_W'(1);
                else if (pick < 25)
                    row.pos = POS_W'(limit + 1);
                else
                    row.pos = POS_W'($urandom_range(1, limit));
            end
            send_request(row);
        end
        i_valid = 1'b0;
        quiet = 1'b0;

        // drain and settle
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
